/* rtl/bps_pkg.sv */
// Shared types and constants for the beep pattern sequencer.
// No dependencies; every other RTL file uses these by scoped name.
`default_nettype none

package bps_pkg;

	localparam int QUEUE_DEPTH = 4;
	localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic {
		CMD_ENQUEUE = 1'b0,
		CMD_UPDATE  = 1'b1
	} cmd_t;

	typedef struct packed {
		logic [15:0] on_ms;
		logic [15:0] period_ms;
		logic [7:0]  repeats;
	} tone_pattern_t;

	typedef struct packed {
		logic        cmd;
		logic [31:0] now_ms;
		logic [15:0] on_ms;
		logic [15:0] period_ms;
		logic [7:0]  repeats;
	} item_t;

	typedef struct packed {
		logic beep_level;
		logic playing;
		logic enqueue_dropped;
	} result_t;

endpackage

`default_nettype wire

/* rtl/bps_item_if.sv */
// Valid/ready channel carrying one command transaction.
// Depends on bps_pkg for the payload type.
`default_nettype none

interface bps_item_if;
	logic            valid;
	logic            ready;
	bps_pkg::item_t  data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/bps_result_if.sv */
// Valid/ready channel carrying one status result transaction.
// Depends on bps_pkg for the payload type.
`default_nettype none

interface bps_result_if;
	logic             valid;
	logic             ready;
	bps_pkg::result_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/beep_pattern_sequencer.sv */
// Beep pattern sequencer top level: pattern queue, period timer, pin state.
// Depends on bps_pkg, bps_item_if and bps_result_if.
`default_nettype none

// Every accepted command transaction produces exactly one status result
// (pin level, playing flag, drop flag) that shows the state after that
// command. Enqueue commands push a pattern into a QUEUE_DEPTH-entry queue or
// flag a drop when it is full; update commands carry the millisecond time
// and advance the player. One command is taken per clock: the whole update
// is combinational logic around one 32-bit subtract between the state
// registers and the result register, so throughput is set only by the
// result register, which accepts a new command whenever it is empty or is
// being drained in the same cycle. The result is registered and is valid in
// the cycle after acceptance. There is no clearing pass after reset; queue
// entries hold no reset value and are only read after being written.
module beep_pattern_sequencer (
	input  wire          clk,
	input  wire          arst_n,
	bps_item_if.sink     items,
	bps_result_if.source results
);

	localparam int                        IDX_W = bps_pkg::IDX_W;
	localparam int                        CNT_W = bps_pkg::CNT_W;
	localparam logic [IDX_W:0]            DEPTH_X = (IDX_W + 1)'(bps_pkg::QUEUE_DEPTH);
	localparam logic [IDX_W-1:0]          LAST_IDX = IDX_W'(bps_pkg::QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0]          FULL_CNT = CNT_W'(bps_pkg::QUEUE_DEPTH);

	// Queue storage, no reset: an entry is read only after it was pushed.
	bps_pkg::tone_pattern_t fifo_q [bps_pkg::QUEUE_DEPTH];

	logic [IDX_W-1:0]  head_q;
	logic [CNT_W-1:0]  count_q;
	bps_pkg::tone_pattern_t active_q;
	logic              active_flag_q;
	logic [31:0]       period_start_q;
	logic [7:0]        periods_done_q;
	logic              pin_q;

	logic              out_valid_q;
	bps_pkg::result_t  out_data_q;

	// Next-state values
	logic              accept;
	logic              push;
	logic              pop;
	logic [IDX_W-1:0]  tail_idx;
	logic [IDX_W:0]    tail_sum;
	logic [IDX_W-1:0]  head_d;
	logic [CNT_W-1:0]  count_d;
	bps_pkg::tone_pattern_t active_d;
	logic              active_flag_d;
	logic [31:0]       period_start_d;
	logic [7:0]        periods_done_d;
	logic              pin_d;
	logic              dropped_d;
	logic [31:0]       elapsed;
	logic [7:0]        done_inc;
	bps_pkg::item_t    item;

	assign item   = items.data;
	// Output register frees up when empty or when its result leaves now.
	assign items.ready = !out_valid_q || results.ready;
	assign accept = items.valid && items.ready;

	// Slot after the newest entry, wrapped at the queue depth.
	assign tail_sum = {1'b0, head_q} + (IDX_W + 1)'(count_q);
	assign tail_idx = (tail_sum >= DEPTH_X) ? IDX_W'(tail_sum - DEPTH_X) : tail_sum[IDX_W-1:0];

	assign elapsed  = item.now_ms - period_start_q;
	assign done_inc = periods_done_q + 8'd1;

	always_comb begin
		push           = 1'b0;
		pop            = 1'b0;
		head_d         = head_q;
		count_d        = count_q;
		active_d       = active_q;
		active_flag_d  = active_flag_q;
		period_start_d = period_start_q;
		periods_done_d = periods_done_q;
		pin_d          = pin_q;
		dropped_d      = 1'b0;

		case (bps_pkg::cmd_t'(item.cmd))
			bps_pkg::CMD_ENQUEUE: begin
				if (count_q != FULL_CNT) begin
					push    = 1'b1;
					count_d = count_q + CNT_W'(1);
				end else begin
					dropped_d = 1'b1;
				end
			end
			bps_pkg::CMD_UPDATE: begin
				if (active_flag_q) begin
					if (elapsed < {16'd0, active_q.on_ms}) begin
						pin_d = 1'b1;
					end else if (elapsed < {16'd0, active_q.period_ms}) begin
						pin_d = 1'b0;
					end else begin
						// period end: pin holds, timer restarts
						periods_done_d = done_inc;
						period_start_d = item.now_ms;
						if (done_inc >= active_q.repeats) begin
							active_flag_d = 1'b0;
						end
					end
				end else begin
					// idle: start the next pattern if one is queued
					if (count_q != '0) begin
						pop           = 1'b1;
						active_d      = fifo_q[head_q];
						head_d        = (head_q == LAST_IDX) ? '0 : head_q + IDX_W'(1);
						count_d       = count_q - CNT_W'(1);
						active_flag_d = 1'b1;
					end
					period_start_d = item.now_ms;
					periods_done_d = 8'd0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept && push) begin
			fifo_q[tail_idx] <= '{on_ms: item.on_ms, period_ms: item.period_ms,
				repeats: item.repeats};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q         <= '0;
			count_q        <= '0;
			active_q       <= '0;
			active_flag_q  <= 1'b0;
			period_start_q <= '0;
			periods_done_q <= '0;
			pin_q          <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (accept) begin
				head_q         <= head_d;
				count_q        <= count_d;
				active_flag_q  <= active_flag_d;
				period_start_q <= period_start_d;
				periods_done_q <= periods_done_d;
				pin_q          <= pin_d;
				if (pop) begin
					active_q <= active_d;
				end
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload register
	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q.beep_level      <= pin_d;
			out_data_q.playing         <= active_flag_d;
			out_data_q.enqueue_dropped <= dropped_d;
		end
	end

	assign results.valid = out_valid_q;
	assign results.data  = out_data_q;

endmodule

`default_nettype wire
